// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. Define NO_ASSERTIONS to
// compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/psh_pkg.sv =====
// ---------------------------------------------------------------------------
// Password scramble hash package
// Word types, constants and the output character table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psh_pkg;

   localparam int unsigned OUT_CHARS_DEF = 10;
   localparam int unsigned SYM_W         = 6;

   localparam logic [31:0] INJECT_PATTERN = 32'h8000_8000;

   localparam logic [8*64-1:0] SYM_TABLE =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuwvxuz0123456789+-";

   typedef struct packed {
      logic [7:0] pass_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] hash_char;
      logic       final_char;
   } rsp_type;

   // The first table character sits in the top byte of the packed string,
   // so entry i starts at byte 63 - i, which is the bitwise inverse of i.
   function automatic logic [7:0] sym_char(input logic [SYM_W-1:0] idx);
      logic [SYM_W+2:0] base;
      base = {~idx, 3'b000};
      return SYM_TABLE[base +: 8];
   endfunction

endpackage

// ===== src/password_scramble_hash_unit.sv =====
// ---------------------------------------------------------------------------
// Password scramble hash unit
// Bit-serial password scrambler with an OUT_CHARS-character encoded result, ten by default.
// ---------------------------------------------------------------------------
// Each accepted byte is taken in the idle state and then scrambled one bit
// per cycle through the shared round unit. After the last byte the round
// unit keeps running until the 64-bit feed pair has shifted out and reads as
// zero, and then OUT_CHARS words are emitted, one per cycle when the result
// side does not stall. The input side is stalled whenever the round
// sequencer is busy; a final result word still waiting in the output register
// does not hold off the next password.
`timescale 1ns / 1ps

module password_scramble_hash_unit
   import psh_pkg::*;
#(
   parameter int unsigned OUT_CHARS = OUT_CHARS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   localparam int unsigned CNT_W = (OUT_CHARS > 1) ? $clog2(OUT_CHARS) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(OUT_CHARS - 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BYTE  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0] chr_cnt_ff, chr_cnt_in;
   logic        last_ff, last_in;
   logic [7:0]  byte_ff, byte_in;

   logic [63:0] feed_ff, feed_in;
   logic [63:0] mix_ff, mix_in;
   logic [63:0] acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_take;
   logic        out_free;
   logic        emit_load;
   logic        feed_zero;
   logic        do_round;
   logic        inject;

   // Round unit signals
   logic [63:0] feed_eff;
   logic [31:0] mh1, ml1, mh2, ml2;
   logic [63:0] mix_sh;
   logic [31:0] ah_n, al_n, mh_n, ml_n;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = (state_ff == S_EMIT) && out_free;
   assign feed_zero = (feed_ff == 64'd0);
   assign inject    = (state_ff == S_BYTE) && byte_ff[0];
   assign do_round  = (state_ff == S_BYTE) || ((state_ff == S_DRAIN) && !feed_zero);

   // One scrambling round. The shifted term is the mix pair before the round
   // shifted right by two; the feed pair is XORed in and not taken back out.
   always_comb begin
      feed_eff = feed_ff | (inject ? {INJECT_PATTERN, INJECT_PATTERN} : 64'd0);
      mh1      = mix_ff[63:32] ^ feed_eff[63:32];
      ml1      = mix_ff[31:0]  ^ feed_eff[31:0];
      mix_sh   = mix_ff >> 2;
      mh2      = mh1 ^ mix_sh[63:32];
      ml2      = ml1 ^ mix_sh[31:0];
      ah_n     = (~acc_ff[63:32]) ^ mh2;
      al_n     = (32'd0 - acc_ff[31:0]) ^ ml2;
      mh_n     = ah_n ^ (~mh2);
      ml_n     = al_n ^ (32'd0 - ml2);
   end

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      chr_cnt_in   = chr_cnt_ff;
      last_in      = last_ff;
      byte_in      = byte_ff;
      feed_in      = feed_ff;
      mix_in       = mix_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (do_round) begin
         feed_in = feed_eff >> 1;
         mix_in  = {mh_n, ml_n};
         acc_in  = {ah_n, al_n};
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               byte_in    = req_data.pass_byte;
               last_in    = req_data.final_byte;
               bit_cnt_in = 3'd0;
               state_in   = S_BYTE;
            end
         end
         S_BYTE: begin
            byte_in    = byte_ff >> 1;
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               state_in = last_ff ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            if (feed_zero) begin
               chr_cnt_in = '0;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.hash_char  = sym_char(acc_ff[SYM_W-1:0]);
               rsp_data_in.final_char = (chr_cnt_ff == LAST_CNT);
               acc_in                 = acc_ff >> SYM_W;
               chr_cnt_in             = chr_cnt_ff + CNT_W'(1);
               if (chr_cnt_ff == LAST_CNT) begin
                  // The whole hash state starts over for the next password.
                  feed_in  = '0;
                  mix_in   = '0;
                  acc_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_cnt_ff   <= '0;
         chr_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         feed_ff      <= '0;
         mix_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         chr_cnt_ff   <= chr_cnt_in;
         last_ff      <= last_in;
         feed_ff      <= feed_in;
         mix_ff       <= mix_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Emission only starts once the feed pair has fully drained.
   `ASSERT_IMPL(a_emit_drained, clock, reset, state_ff == S_EMIT, feed_zero)
   // The emit phase is entered from the drain phase only.
   `ASSERT_NEXT(a_emit_from_drain, clock, reset, state_ff != S_EMIT && state_ff != S_DRAIN, state_ff != S_EMIT)
   // Loading the last character clears the hash state and frees the input.
   `ASSERT_NEXT(a_clear_after_last, clock, reset, emit_load && chr_cnt_ff == LAST_CNT, state_ff == S_IDLE && acc_ff == 64'd0 && mix_ff == 64'd0)

endmodule
